FILE: rtl/calu_pkg.sv
`default_nettype none

package calu_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC8  = 5'd8,
		OP_DEC8  = 5'd9,
		OP_DAA   = 5'd10,
		OP_CPL   = 5'd11,
		OP_SCF   = 5'd12,
		OP_CCF   = 5'd13,
		OP_ADDHL = 5'd14,
		OP_ADDSP = 5'd15,
		OP_INC16 = 5'd16,
		OP_DEC16 = 5'd17
	} op_t;

	localparam logic [7:0]  DAA_LO_ADJ   = 8'h06;
	localparam logic [7:0]  DAA_HI_ADJ   = 8'h60;
	localparam logic [7:0]  DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0]  DAA_LO_LIMIT = 4'h9;
	localparam logic [3:0]  NIB_MAX      = 4'hF;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [15:0] first_operand;
		logic [15:0] second_operand;
		logic        zero_in;
		logic        negative_in;
		logic        half_in;
		logic        carry_in;
	} req_t;

	typedef struct packed {
		logic [15:0] result_value;
		logic        zero_out;
		logic        negative_out;
		logic        half_out;
		logic        carry_out;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/calu_req_if.sv
`default_nettype none

interface calu_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  req_type;
	logic [15:0] first_operand;
	logic [15:0] second_operand;
	logic        zero_in;
	logic        negative_in;
	logic        half_in;
	logic        carry_in;

	modport source (
		output valid, req_type, first_operand, second_operand,
		output zero_in, negative_in, half_in, carry_in,
		input  ready
	);

	modport sink (
		input  valid, req_type, first_operand, second_operand,
		input  zero_in, negative_in, half_in, carry_in,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/calu_rsp_if.sv
`default_nettype none

interface calu_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_value;
	logic        zero_out;
	logic        negative_out;
	logic        half_out;
	logic        carry_out;

	modport source (
		output valid, result_value, zero_out, negative_out, half_out, carry_out,
		input  ready
	);

	modport sink (
		input  valid, result_value, zero_out, negative_out, half_out, carry_out,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/calu_core.sv
`default_nettype none

module calu_core (
	input  calu_pkg::req_t op_req,
	output calu_pkg::rsp_t op_rsp
);

	logic [15:0] p;
	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic        t;
	logic [8:0]  sum9;
	logic [4:0]  hsum5;
	logic [8:0]  diff9;
	logic [4:0]  hdiff5;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [7:0]  daa_adj;
	logic        daa_lo;
	logic        daa_hi;
	logic [7:0]  daa_res;
	logic [16:0] hl_sum;
	logic [12:0] hl_half;
	logic [15:0] sp_sum;
	logic [4:0]  sp_half;
	logic [8:0]  sp_carry;

	assign p   = op_req.first_operand;
	assign a   = op_req.first_operand[7:0];
	assign b   = op_req.second_operand[7:0];
	assign cin = op_req.carry_in;
	assign t   = ((op_req.req_type == calu_pkg::OP_ADC) ||
		(op_req.req_type == calu_pkg::OP_SBC)) ? cin : 1'b0;

	assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, t};
	assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
	assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, t};
	assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
	assign inc8   = a + 8'd1;
	assign dec8   = a - 8'd1;

	// Decimal adjust: after a subtraction only the incoming H and C pick the correction.
	assign daa_lo  = op_req.half_in | (~op_req.negative_in & (a[3:0] > calu_pkg::DAA_LO_LIMIT));
	assign daa_hi  = cin | (~op_req.negative_in & (a > calu_pkg::DAA_HI_LIMIT));
	assign daa_adj = (daa_lo ? calu_pkg::DAA_LO_ADJ : 8'd0) |
		(daa_hi ? calu_pkg::DAA_HI_ADJ : 8'd0);
	assign daa_res = op_req.negative_in ? (a - daa_adj) : (a + daa_adj);

	assign hl_sum   = {1'b0, p} + {1'b0, op_req.second_operand};
	assign hl_half  = {1'b0, p[11:0]} + {1'b0, op_req.second_operand[11:0]};
	assign sp_sum   = p + {{8{b[7]}}, b};
	assign sp_half  = {1'b0, p[3:0]} + {1'b0, b[3:0]};
	assign sp_carry = {1'b0, p[7:0]} + {1'b0, b};

	always_comb begin
		op_rsp.result_value = p;
		op_rsp.zero_out     = op_req.zero_in;
		op_rsp.negative_out = op_req.negative_in;
		op_rsp.half_out     = op_req.half_in;
		op_rsp.carry_out    = cin;
		unique case (op_req.req_type)
			calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
				op_rsp.result_value = {8'd0, sum9[7:0]};
				op_rsp.zero_out     = (sum9[7:0] == 8'd0);
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = hsum5[4];
				op_rsp.carry_out    = sum9[8];
			end
			calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP: begin
				if (op_req.req_type != calu_pkg::OP_CP) begin
					op_rsp.result_value = {8'd0, diff9[7:0]};
				end
				op_rsp.zero_out     = (diff9[7:0] == 8'd0);
				op_rsp.negative_out = 1'b1;
				op_rsp.half_out     = hdiff5[4];
				op_rsp.carry_out    = diff9[8];
			end
			calu_pkg::OP_AND: begin
				op_rsp.result_value = {8'd0, a & b};
				op_rsp.zero_out     = ((a & b) == 8'd0);
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = 1'b1;
				op_rsp.carry_out    = 1'b0;
			end
			calu_pkg::OP_XOR: begin
				op_rsp.result_value = {8'd0, a ^ b};
				op_rsp.zero_out     = ((a ^ b) == 8'd0);
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = 1'b0;
				op_rsp.carry_out    = 1'b0;
			end
			calu_pkg::OP_OR: begin
				op_rsp.result_value = {8'd0, a | b};
				op_rsp.zero_out     = ((a | b) == 8'd0);
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = 1'b0;
				op_rsp.carry_out    = 1'b0;
			end
			calu_pkg::OP_INC8: begin
				op_rsp.result_value = {8'd0, inc8};
				op_rsp.zero_out     = (inc8 == 8'd0);
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = (a[3:0] == calu_pkg::NIB_MAX);
			end
			calu_pkg::OP_DEC8: begin
				op_rsp.result_value = {8'd0, dec8};
				op_rsp.zero_out     = (dec8 == 8'd0);
				op_rsp.negative_out = 1'b1;
				op_rsp.half_out     = (a[3:0] == 4'd0);
			end
			calu_pkg::OP_DAA: begin
				op_rsp.result_value = {8'd0, daa_res};
				op_rsp.zero_out     = (daa_res == 8'd0);
				op_rsp.half_out     = 1'b0;
				op_rsp.carry_out    = daa_hi;
			end
			calu_pkg::OP_CPL: begin
				op_rsp.result_value = {8'd0, ~a};
				op_rsp.negative_out = 1'b1;
				op_rsp.half_out     = 1'b1;
			end
			calu_pkg::OP_SCF: begin
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = 1'b0;
				op_rsp.carry_out    = 1'b1;
			end
			calu_pkg::OP_CCF: begin
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = 1'b0;
				op_rsp.carry_out    = ~cin;
			end
			calu_pkg::OP_ADDHL: begin
				op_rsp.result_value = hl_sum[15:0];
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = hl_half[12];
				op_rsp.carry_out    = hl_sum[16];
			end
			calu_pkg::OP_ADDSP: begin
				op_rsp.result_value = sp_sum;
				op_rsp.zero_out     = 1'b0;
				op_rsp.negative_out = 1'b0;
				op_rsp.half_out     = sp_half[4];
				op_rsp.carry_out    = sp_carry[8];
			end
			calu_pkg::OP_INC16: begin
				op_rsp.result_value = p + 16'd1;
			end
			calu_pkg::OP_DEC16: begin
				op_rsp.result_value = p - 16'd1;
			end
			default: begin
				op_rsp.result_value = p;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/cpu_alu_with_flags_unit.sv
`default_nettype none

// Channel  Modport  Transaction content
// req      sink     req_type, first_operand, second_operand, zero/negative/half/carry_in
// rsp      source   result_value, zero/negative/half/carry_out
//
// Each transaction passes an input register and then a result register before its
// result appears on rsp; one transaction is taken every cycle unless req backs up.
// The ALU itself is a single combinational pass between the two registers.
// Reset clears only the two valid bits; payload registers are not reset.
// A stall on rsp holds the result register, and req backs up only when both
// registers are full.

module cpu_alu_with_flags_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	calu_req_if.sink    req,
	calu_rsp_if.source  rsp
);

	calu_pkg::req_t req_s1;
	calu_pkg::rsp_t rsp_s2;
	calu_pkg::rsp_t core_rsp;
	logic           valid_s1;
	logic           valid_s2;
	logic           adv_s2;
	logic           adv_s1;

	assign adv_s2    = ~valid_s2 | rsp.ready;
	assign adv_s1    = ~valid_s1 | adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1.req_type       <= req.req_type;
			req_s1.first_operand  <= req.first_operand;
			req_s1.second_operand <= req.second_operand;
			req_s1.zero_in        <= req.zero_in;
			req_s1.negative_in    <= req.negative_in;
			req_s1.half_in        <= req.half_in;
			req_s1.carry_in       <= req.carry_in;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	calu_core u_core (
		.op_req (req_s1),
		.op_rsp (core_rsp)
	);

	assign rsp.valid        = valid_s2;
	assign rsp.result_value = rsp_s2.result_value;
	assign rsp.zero_out     = rsp_s2.zero_out;
	assign rsp.negative_out = rsp_s2.negative_out;
	assign rsp.half_out     = rsp_s2.half_out;
	assign rsp.carry_out    = rsp_s2.carry_out;

endmodule

`default_nettype wire

FILE: tb/cpu_alu_with_flags_unit_test.sv
`timescale 1ns / 100ps

module cpu_alu_with_flags_unit_test;

	localparam logic [4:0] OP_CODE_MAX = 5'd31;
	localparam int IDLE_PERCENT = 14;
	localparam int RANDOM_ITEMS = 1050;
	localparam int DIR_ROWS = 25;

	typedef struct packed {
		calu_pkg::req_t stim;
		logic typed;
		calu_pkg::rsp_t want;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{'{calu_pkg::OP_ADD, 16'h12FF, 16'hFF01, 1'b0, 1'b1, 1'b0, 1'b0},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b1}},
		'{'{calu_pkg::OP_ADC, 16'h000F, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_ADD, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{calu_pkg::OP_SUB, 16'h0000, 16'h0001, 1'b1, 1'b0, 1'b0, 1'b0},
			1'b1, '{16'h00FF, 1'b0, 1'b1, 1'b1, 1'b1}},
		'{'{calu_pkg::OP_SBC, 16'h0010, 16'h000F, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_SBC, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_AND, 16'h00F0, 16'h000F, 1'b0, 1'b1, 1'b0, 1'b1},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{'{calu_pkg::OP_XOR, 16'h00FF, 16'h00FF, 1'b0, 1'b1, 1'b1, 1'b1},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{calu_pkg::OP_OR, 16'hA55A, 16'h5AA5, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_CP, 16'hBE42, 16'h0042, 1'b0, 1'b0, 1'b1, 1'b1},
			1'b1, '{16'hBE42, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{'{calu_pkg::OP_INC8, 16'h00FF, 16'h1234, 1'b0, 1'b1, 1'b0, 1'b1},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b1}},
		'{'{calu_pkg::OP_DEC8, 16'hFF00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
			1'b1, '{16'h00FF, 1'b0, 1'b1, 1'b1, 1'b0}},
		'{'{calu_pkg::OP_DAA, 16'h009A, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{calu_pkg::OP_DAA, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_DAA, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{calu_pkg::OP_CPL, 16'hFF00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
			1'b1, '{16'h00FF, 1'b1, 1'b1, 1'b1, 1'b0}},
		'{'{calu_pkg::OP_SCF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
			1'b1, '{16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1}},
		'{'{calu_pkg::OP_CCF, 16'h1357, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_ADDHL, 16'hFFFF, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b1}},
		'{'{calu_pkg::OP_ADDHL, 16'h0FFF, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{calu_pkg::OP_ADDSP, 16'h0000, 16'hFF80, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{calu_pkg::OP_ADDSP, 16'hFFFF, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b1},
			1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b1}},
		'{'{calu_pkg::OP_INC16, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
			1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{'{calu_pkg::OP_DEC16, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1},
			1'b1, '{16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1}},
		'{'{OP_CODE_MAX, 16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 1'b1},
			1'b1, '{16'h1234, 1'b1, 1'b1, 1'b1, 1'b1}}
	};

	logic clk;
	logic arst_n;
	logic calm;
	int mismatches;
	calu_pkg::rsp_t pending_results[$];

	calu_req_if req_ch();
	calu_rsp_if rsp_ch();

	cpu_alu_with_flags_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic calu_pkg::rsp_t alu_outcome(calu_pkg::req_t rq);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] r8;
		logic [7:0] adj;
		logic [8:0] sum9;
		logic [4:0] nib;
		logic [12:0] sum13;
		logic [16:0] sum17;
		logic t;
		calu_pkg::rsp_t res;
		a = rq.first_operand[7:0];
		b = rq.second_operand[7:0];
		t = 1'b0;
		res.result_value = rq.first_operand;
		res.zero_out = rq.zero_in;
		res.negative_out = rq.negative_in;
		res.half_out = rq.half_in;
		res.carry_out = rq.carry_in;
		case (rq.req_type)
			calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
				if (rq.req_type == calu_pkg::OP_ADC)
					t = rq.carry_in;
				sum9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
				res.result_value = {8'h00, sum9[7:0]};
				res.zero_out = (sum9[7:0] == 8'h00);
				res.negative_out = 1'b0;
				res.half_out = nib[4];
				res.carry_out = sum9[8];
			end
			calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP: begin
				if (rq.req_type == calu_pkg::OP_SBC)
					t = rq.carry_in;
				r8 = a - b - {7'h00, t};
				res.zero_out = (r8 == 8'h00);
				res.negative_out = 1'b1;
				res.half_out = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, t});
				res.carry_out = {1'b0, a} < ({1'b0, b} + {8'h00, t});
				if (rq.req_type != calu_pkg::OP_CP)
					res.result_value = {8'h00, r8};
			end
			calu_pkg::OP_AND, calu_pkg::OP_XOR, calu_pkg::OP_OR: begin
				if (rq.req_type == calu_pkg::OP_AND)
					r8 = a & b;
				else if (rq.req_type == calu_pkg::OP_XOR)
					r8 = a ^ b;
				else
					r8 = a | b;
				res.result_value = {8'h00, r8};
				res.zero_out = (r8 == 8'h00);
				res.negative_out = 1'b0;
				res.half_out = (rq.req_type == calu_pkg::OP_AND);
				res.carry_out = 1'b0;
			end
			calu_pkg::OP_INC8: begin
				r8 = a + 8'h01;
				res.result_value = {8'h00, r8};
				res.zero_out = (r8 == 8'h00);
				res.negative_out = 1'b0;
				res.half_out = (a[3:0] == calu_pkg::NIB_MAX);
			end
			calu_pkg::OP_DEC8: begin
				r8 = a - 8'h01;
				res.result_value = {8'h00, r8};
				res.zero_out = (r8 == 8'h00);
				res.negative_out = 1'b1;
				res.half_out = (a[3:0] == 4'h0);
			end
			calu_pkg::OP_DAA: begin
				adj = 8'h00;
				if (rq.negative_in) begin
					if (rq.half_in)
						adj = adj + calu_pkg::DAA_LO_ADJ;
					if (rq.carry_in)
						adj = adj + calu_pkg::DAA_HI_ADJ;
					r8 = a - adj;
				end else begin
					if (rq.half_in || a[3:0] > calu_pkg::DAA_LO_LIMIT)
						adj = adj + calu_pkg::DAA_LO_ADJ;
					if (rq.carry_in || a > calu_pkg::DAA_HI_LIMIT) begin
						adj = adj + calu_pkg::DAA_HI_ADJ;
						res.carry_out = 1'b1;
					end
					r8 = a + adj;
				end
				res.result_value = {8'h00, r8};
				res.zero_out = (r8 == 8'h00);
				res.half_out = 1'b0;
			end
			calu_pkg::OP_CPL: begin
				res.result_value = {8'h00, ~a};
				res.negative_out = 1'b1;
				res.half_out = 1'b1;
			end
			calu_pkg::OP_SCF, calu_pkg::OP_CCF: begin
				res.negative_out = 1'b0;
				res.half_out = 1'b0;
				res.carry_out = (rq.req_type == calu_pkg::OP_SCF) ? 1'b1 : ~rq.carry_in;
			end
			calu_pkg::OP_ADDHL: begin
				sum17 = {1'b0, rq.first_operand} + {1'b0, rq.second_operand};
				sum13 = {1'b0, rq.first_operand[11:0]} + {1'b0, rq.second_operand[11:0]};
				res.result_value = sum17[15:0];
				res.negative_out = 1'b0;
				res.half_out = sum13[12];
				res.carry_out = sum17[16];
			end
			calu_pkg::OP_ADDSP: begin
				nib = {1'b0, rq.first_operand[3:0]} + {1'b0, b[3:0]};
				sum9 = {1'b0, rq.first_operand[7:0]} + {1'b0, b};
				res.result_value = rq.first_operand + {{8{b[7]}}, b};
				res.zero_out = 1'b0;
				res.negative_out = 1'b0;
				res.half_out = nib[4];
				res.carry_out = sum9[8];
			end
			calu_pkg::OP_INC16: res.result_value = rq.first_operand + 16'h0001;
			calu_pkg::OP_DEC16: res.result_value = rq.first_operand - 16'h0001;
			default: res.result_value = rq.first_operand;
		endcase
		return res;
	endfunction

	function automatic calu_pkg::req_t random_request();
		calu_pkg::req_t rq;
		if ($urandom_range(0, 99) < 5)
			rq.req_type = 5'($urandom_range(int'(calu_pkg::OP_DEC16) + 1,
				int'(OP_CODE_MAX)));
		else
			rq.req_type = 5'($urandom_range(0, int'(calu_pkg::OP_DEC16)));
		rq.first_operand = 16'($urandom);
		rq.second_operand = 16'($urandom);
		if ($urandom_range(0, 9) == 0)
			rq.second_operand[7:0] = rq.first_operand[7:0];
		{rq.zero_in, rq.negative_in, rq.half_in, rq.carry_in} = 4'($urandom);
		return rq;
	endfunction

	task automatic send_op(calu_pkg::req_t rq, logic typed, calu_pkg::rsp_t want);
		logic taken;
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rq.req_type;
		req_ch.first_operand <= rq.first_operand;
		req_ch.second_operand <= rq.second_operand;
		req_ch.zero_in <= rq.zero_in;
		req_ch.negative_in <= rq.negative_in;
		req_ch.half_in <= rq.half_in;
		req_ch.carry_in <= rq.carry_in;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(typed ? want : alu_outcome(rq));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= arst_n && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	always @(negedge clk) begin
		calu_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h %b%b%b%b", $time,
					rsp_ch.result_value, rsp_ch.zero_out, rsp_ch.negative_out,
					rsp_ch.half_out, rsp_ch.carry_out);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("result_value", want.result_value, rsp_ch.result_value);
				compare_field("zero_out", 16'(want.zero_out), 16'(rsp_ch.zero_out));
				compare_field("negative_out", 16'(want.negative_out),
					16'(rsp_ch.negative_out));
				compare_field("half_out", 16'(want.half_out), 16'(rsp_ch.half_out));
				compare_field("carry_out", 16'(want.carry_out), 16'(rsp_ch.carry_out));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.first_operand = '0;
		req_ch.second_operand = '0;
		req_ch.zero_in = 1'b0;
		req_ch.negative_in = 1'b0;
		req_ch.half_in = 1'b0;
		req_ch.carry_in = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			send_op(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
		drain_results();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm <= (i >= 400 && i < 600);
			if (i == 700)
				drain_results();
			send_op(random_request(), 1'b0, '0);
		end
		calm <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
